>>> hdl/tile_crop_reorder_core_assert.svh
// Assertion macros shared by the tile reorder RTL.
`ifndef TILE_CROP_REORDER_CORE_ASSERT_SVH
`define TILE_CROP_REORDER_CORE_ASSERT_SVH

// Implication in the same cycle, checked on the rising clock edge outside reset.
`define TCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, checked on the rising clock edge outside reset.
`define TCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tcr_pkg.sv
// Shared types, constants and register codes of the tile reorder block.
`timescale 1ns / 1ps
`default_nettype none
package tcr_pkg;

	localparam int DEF_STORE_DEPTH  = 262144;
	localparam int DEF_ELEMENT_BITS = 16;

	localparam int CH_W     = 3;
	localparam int EDGE_W   = 11;
	localparam int INDEX_W  = 2;
	localparam int VALUE_W  = 16;
	localparam int PROD_W   = 22;
	localparam int CHW_W    = 25;

	localparam logic [CH_W-1:0]   MAX_CHANNELS = 3'd4;
	localparam logic [EDGE_W-1:0] MAX_EDGE     = 11'd1024;

	localparam logic [CH_W-1:0]   RST_CHANNELS = 3'd3;
	localparam logic [EDGE_W-1:0] RST_HEIGHT   = 11'd224;
	localparam logic [EDGE_W-1:0] RST_WIDTH    = 11'd224;
	localparam logic [EDGE_W-1:0] RST_TILE     = 11'd112;

	localparam logic [INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd2;
	localparam logic [INDEX_W-1:0] REG_TILE_EDGE     = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0]   channel_count;
		logic [EDGE_W-1:0] frame_height;
		logic [EDGE_W-1:0] frame_width;
		logic [EDGE_W-1:0] tile_edge;
	} cfg_t;

	typedef struct packed {
		logic              busy;
		logic              bad;
		logic [PROD_W-1:0] hw;
		logic [PROD_W-1:0] tw;
		logic [CHW_W-1:0]  chw;
	} chk_t;

endpackage
`default_nettype wire

>>> hdl/tcr_frame_mem.sv
// Frame store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tcr_frame_mem #(
	parameter int DEPTH  = tcr_pkg::DEF_STORE_DEPTH,
	parameter int DATA_W = tcr_pkg::DEF_ELEMENT_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/tcr_cfg_check.sv
// Configuration checker: tile divisibility, ranges and frame size products.
`timescale 1ns / 1ps
`default_nettype none
module tcr_cfg_check #(
	parameter int STORE_DEPTH = tcr_pkg::DEF_STORE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tcr_pkg::cfg_t cfg,
	output tcr_pkg::chk_t      chk
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam int CNT_W = $clog2(tcr_pkg::EDGE_W);

	logic [1:0]                  state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            bit_idx;
	logic [tcr_pkg::EDGE_W-1:0]  rem_h_q;
	logic [tcr_pkg::EDGE_W-1:0]  rem_w_q;
	logic                        bad_q;
	logic                        range_bad;
	logic [tcr_pkg::PROD_W-1:0]  hw_q;
	logic [tcr_pkg::PROD_W-1:0]  tw_q;
	logic [tcr_pkg::CHW_W-1:0]   chw_q;

	function automatic logic [tcr_pkg::EDGE_W-1:0] div_step(
		input logic [tcr_pkg::EDGE_W-1:0] rem,
		input logic                       nbit,
		input logic [tcr_pkg::EDGE_W-1:0] dvs
	);
		logic [tcr_pkg::EDGE_W:0] r;
		r = {rem, nbit};
		if (r >= {1'b0, dvs}) begin
			r = r - {1'b0, dvs};
		end
		return r[tcr_pkg::EDGE_W-1:0];
	endfunction

	assign bit_idx = CNT_W'(tcr_pkg::EDGE_W - 1) - cnt_q;

	assign range_bad = (cfg.channel_count == '0) || (cfg.channel_count > tcr_pkg::MAX_CHANNELS)
		|| (cfg.frame_height == '0) || (cfg.frame_height > tcr_pkg::MAX_EDGE)
		|| (cfg.frame_width == '0) || (cfg.frame_width > tcr_pkg::MAX_EDGE)
		|| (cfg.tile_edge == '0) || (cfg.tile_edge > tcr_pkg::MAX_EDGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			rem_h_q <= '0;
			rem_w_q <= '0;
			bad_q   <= 1'b1;
		end else if (start) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			rem_h_q <= '0;
			rem_w_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					rem_h_q <= div_step(rem_h_q, cfg.frame_height[bit_idx], cfg.tile_edge);
					rem_w_q <= div_step(rem_w_q, cfg.frame_width[bit_idx], cfg.tile_edge);
					cnt_q   <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(tcr_pkg::EDGE_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					bad_q   <= range_bad || (rem_h_q != '0) || (rem_w_q != '0)
						|| (chw_q > tcr_pkg::CHW_W'(STORE_DEPTH));
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hw_q  <= tcr_pkg::PROD_W'(cfg.frame_height) * tcr_pkg::PROD_W'(cfg.frame_width);
		tw_q  <= tcr_pkg::PROD_W'(cfg.tile_edge) * tcr_pkg::PROD_W'(cfg.frame_width);
		chw_q <= tcr_pkg::CHW_W'(cfg.channel_count) * tcr_pkg::CHW_W'(hw_q);
	end

	always_comb begin
		chk.busy = (state_q != ST_IDLE);
		chk.bad  = bad_q;
		chk.hw   = hw_q;
		chk.tw   = tw_q;
		chk.chw  = chw_q;
	end

endmodule
`default_nettype wire

>>> hdl/tcr_addr_gen.sv
// Load pointer and tile-order emit counters with incremental address update.
`timescale 1ns / 1ps
`default_nettype none
module tcr_addr_gen #(
	parameter int STORE_DEPTH = tcr_pkg::DEF_STORE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           clear,
	input  wire logic                           load_adv,
	input  wire logic                           emit_adv,
	input  wire tcr_pkg::cfg_t                  cfg,
	input  wire tcr_pkg::chk_t                  chk,
	output logic      [$clog2(STORE_DEPTH)-1:0] wr_addr,
	output logic      [$clog2(STORE_DEPTH)-1:0] rd_addr,
	output logic                                tile_done,
	output logic                                frame_done
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = (AW + 1 > tcr_pkg::CHW_W) ? AW + 1 : tcr_pkg::CHW_W;
	localparam int EW = tcr_pkg::EDGE_W;

	logic [AW-1:0]   lp_q;
	logic [EW-2:0]   col_in_q;
	logic [EW-2:0]   row_in_q;
	logic [1:0]      ch_q;
	logic [EW-1:0]   tcol_base_q;
	logic [EW-1:0]   trow_base_q;
	logic [PW-1:0]   plane_q;
	logic [PW-1:0]   row_addr_q;
	logic [PW-1:0]   trow_addr_q;

	logic [PW-1:0]   lp_next;
	logic [PW-1:0]   lp_limit;
	logic [PW-1:0]   addr_full;
	logic [PW-1:0]   trow_addr_next;
	logic            last_col;
	logic            last_row;
	logic            last_ch;
	logic            last_tc;
	logic            last_tr;

	assign lp_next  = PW'(lp_q) + PW'(1);
	assign lp_limit = chk.bad ? PW'(STORE_DEPTH) : PW'(chk.chw);
	assign wr_addr  = lp_q;

	assign addr_full = plane_q + row_addr_q + PW'(tcol_base_q) + PW'(col_in_q);
	assign rd_addr   = addr_full[AW-1:0];

	assign last_col = (EW'(col_in_q) + EW'(1)) >= cfg.tile_edge;
	assign last_row = (EW'(row_in_q) + EW'(1)) >= cfg.tile_edge;
	assign last_ch  = (tcr_pkg::CH_W'(ch_q) + tcr_pkg::CH_W'(1)) >= cfg.channel_count;
	assign last_tc  = ({1'b0, tcol_base_q} + {1'b0, cfg.tile_edge}) >= {1'b0, cfg.frame_width};
	assign last_tr  = ({1'b0, trow_base_q} + {1'b0, cfg.tile_edge}) >= {1'b0, cfg.frame_height};

	assign tile_done  = last_col && last_row;
	assign frame_done = last_col && last_row && last_ch && last_tc && last_tr;

	assign trow_addr_next = trow_addr_q + PW'(chk.tw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
		end else if (clear) begin
			lp_q <= '0;
		end else if (load_adv) begin
			lp_q <= (lp_next >= lp_limit) ? '0 : lp_next[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_in_q    <= '0;
			row_in_q    <= '0;
			ch_q        <= '0;
			tcol_base_q <= '0;
			trow_base_q <= '0;
			plane_q     <= '0;
			row_addr_q  <= '0;
			trow_addr_q <= '0;
		end else if (clear) begin
			col_in_q    <= '0;
			row_in_q    <= '0;
			ch_q        <= '0;
			tcol_base_q <= '0;
			trow_base_q <= '0;
			plane_q     <= '0;
			row_addr_q  <= '0;
			trow_addr_q <= '0;
		end else if (emit_adv) begin
			priority if (!last_col) begin
				col_in_q <= col_in_q + (EW-1)'(1);
			end else if (!last_row) begin
				col_in_q   <= '0;
				row_in_q   <= row_in_q + (EW-1)'(1);
				row_addr_q <= row_addr_q + PW'(cfg.frame_width);
			end else if (!last_ch) begin
				col_in_q   <= '0;
				row_in_q   <= '0;
				ch_q       <= ch_q + 2'd1;
				plane_q    <= plane_q + PW'(chk.hw);
				row_addr_q <= trow_addr_q;
			end else if (!last_tc) begin
				col_in_q    <= '0;
				row_in_q    <= '0;
				ch_q        <= '0;
				plane_q     <= '0;
				tcol_base_q <= tcol_base_q + cfg.tile_edge;
				row_addr_q  <= trow_addr_q;
			end else if (!last_tr) begin
				col_in_q    <= '0;
				row_in_q    <= '0;
				ch_q        <= '0;
				plane_q     <= '0;
				tcol_base_q <= '0;
				trow_base_q <= trow_base_q + cfg.tile_edge;
				trow_addr_q <= trow_addr_next;
				row_addr_q  <= trow_addr_next;
			end else begin
				col_in_q    <= '0;
				row_in_q    <= '0;
				ch_q        <= '0;
				plane_q     <= '0;
				tcol_base_q <= '0;
				trow_base_q <= '0;
				trow_addr_q <= '0;
				row_addr_q  <= '0;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/tile_crop_reorder_core.sv
// Tile reorder core: loads a channel-major frame and emits it in tile order.
// Input channel (in_valid/in_ready, func, load_value): func 0 stores one element at
// the load pointer, func 1 requests the next element in tile order. Loads make no result.
// Output channel (out_valid/out_ready): one transfer per emit request carrying the
// element, the end-of-tile and end-of-frame marks, and config_error when the sizes are
// unusable (then the element and marks are zero and the emit position does not move).
// Configuration: cfg_we writes cfg_data into register cfg_index and returns the load
// pointer and emit position to the frame start.
// Throughput is one item per cycle while the size checker is idle and the output is not stalled;
// an emit result is registered twice, as the frame store is read into the read stage at the
// transfer edge and the output register then loads from the read stage.
// After reset and after every configuration write, the size checker runs an eleven-step
// remainder unit and then a step that settles the verdict, and all the while
// in_ready stays low. When the receiver stalls, one result waits in the output
// register and one in the read stage; in_ready then drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module tile_crop_reorder_core #(
	parameter int STORE_DEPTH  = tcr_pkg::DEF_STORE_DEPTH,
	parameter int ELEMENT_BITS = tcr_pkg::DEF_ELEMENT_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire logic [tcr_pkg::VALUE_W-1:0]   load_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [tcr_pkg::VALUE_W-1:0]   element_value,
	output logic                               tile_done,
	output logic                               frame_done,
	output logic                               config_error,
	input  wire logic                          cfg_we,
	input  wire logic [tcr_pkg::INDEX_W-1:0]   cfg_index,
	input  wire logic [tcr_pkg::EDGE_W-1:0]    cfg_data
);

	`include "tile_crop_reorder_core_assert.svh"

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int VW = tcr_pkg::VALUE_W;

	tcr_pkg::cfg_t cfg_q;
	tcr_pkg::chk_t chk;

	logic                       in_xfer;
	logic                       load_xfer;
	logic                       emit_xfer;
	logic                       emit_adv;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;
	logic [ELEMENT_BITS-1:0]    wr_data;
	logic [ELEMENT_BITS-1:0]    rd_data;
	logic [ELEMENT_BITS+VW-1:0] wr_ext;
	logic [ELEMENT_BITS+VW-1:0] rd_ext;
	logic                       gen_tile_done;
	logic                       gen_frame_done;

	logic                       pend_s1;
	logic                       err_s1;
	logic                       tdone_s1;
	logic                       fdone_s1;
	logic                       s1_move;

	logic                       out_valid_q;
	logic [VW-1:0]              elem_q;
	logic                       tdone_q;
	logic                       fdone_q;
	logic                       err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= tcr_pkg::RST_CHANNELS;
			cfg_q.frame_height  <= tcr_pkg::RST_HEIGHT;
			cfg_q.frame_width   <= tcr_pkg::RST_WIDTH;
			cfg_q.tile_edge     <= tcr_pkg::RST_TILE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcr_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[tcr_pkg::CH_W-1:0];
				tcr_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				tcr_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data;
				tcr_pkg::REG_TILE_EDGE:     cfg_q.tile_edge     <= cfg_data;
			endcase
		end
	end

	tcr_cfg_check #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_check (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_we),
		.cfg   (cfg_q),
		.chk   (chk)
	);

	assign s1_move   = pend_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !chk.busy && (!pend_s1 || !out_valid_q || out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign load_xfer = in_xfer && !func;
	assign emit_xfer = in_xfer && func;
	assign emit_adv  = emit_xfer && !chk.bad;

	tcr_addr_gen #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_we),
		.load_adv  (load_xfer),
		.emit_adv  (emit_adv),
		.cfg       (cfg_q),
		.chk       (chk),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.tile_done (gen_tile_done),
		.frame_done(gen_frame_done)
	);

	assign wr_ext  = {{ELEMENT_BITS{1'b0}}, load_value};
	assign wr_data = wr_ext[ELEMENT_BITS-1:0];

	tcr_frame_mem #(
		.DEPTH (STORE_DEPTH),
		.DATA_W(ELEMENT_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (load_xfer),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (emit_adv),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_ext = {{VW{1'b0}}, rd_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (emit_xfer) begin
			pend_s1 <= 1'b1;
		end else if (s1_move) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_xfer) begin
			err_s1   <= chk.bad;
			tdone_s1 <= !chk.bad && gen_tile_done;
			fdone_s1 <= !chk.bad && gen_frame_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			elem_q  <= err_s1 ? '0 : rd_ext[VW-1:0];
			tdone_q <= tdone_s1;
			fdone_q <= fdone_s1;
			err_q   <= err_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign element_value = elem_q;
	assign tile_done     = tdone_q;
	assign frame_done    = fdone_q;
	assign config_error  = err_q;

	`TCR_ASSERT_NEXT(a_emit_reaches_s1, emit_xfer, pend_s1, "emit transfer did not enter read stage")
	`TCR_ASSERT_SAME(a_frame_ends_tile, out_valid_q && fdone_q, tdone_q, "frame end without tile end")
	`TCR_ASSERT_SAME(a_error_result_clean, out_valid_q && err_q, (elem_q == '0) && !tdone_q && !fdone_q, "error result carries data")
	`TCR_ASSERT_NEXT(a_write_starts_check, cfg_we, chk.busy && !in_ready, "register write did not start size check")

endmodule
`default_nettype wire

>>> test/tile_crop_reorder_core_tb.sv
// Self-checking testbench for the tile reorder core: random loads and emits against a tile-order predictor.
`timescale 1ns / 1ps
module tile_crop_reorder_core_tb;

	localparam int STORE_DEPTH = tcr_pkg::DEF_STORE_DEPTH;
	localparam bit FUNC_LOAD = 1'b0;
	localparam bit FUNC_EMIT = 1'b1;
	localparam int LONG_HOLD = 120;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [tcr_pkg::VALUE_W-1:0] value;
		logic                        tile_end;
		logic                        frame_end;
		logic                        cfg_err;
	} tile_result_t;

	class tile_order_predictor;
		int unsigned n_chan, n_rows, n_cols, tile_len;
		logic [tcr_pkg::VALUE_W-1:0] frame_mem [int unsigned];
		int unsigned load_ptr, tile_r, tile_c, chan_at, row_at, col_at;
		tile_result_t awaited[$];
		int fail_count, loads, emits, tile_marks, frame_marks, error_results;

		function new();
			n_chan = tcr_pkg::RST_CHANNELS;
			n_rows = tcr_pkg::RST_HEIGHT;
			n_cols = tcr_pkg::RST_WIDTH;
			tile_len = tcr_pkg::RST_TILE;
			clear_position();
		endfunction

		function void clear_position();
			load_ptr = 0;
			tile_r = 0;
			tile_c = 0;
			chan_at = 0;
			row_at = 0;
			col_at = 0;
		endfunction

		function void write_reg(logic [tcr_pkg::INDEX_W-1:0] idx,
				logic [tcr_pkg::EDGE_W-1:0] data);
			case (idx)
				tcr_pkg::REG_CHANNEL_COUNT: n_chan = data[tcr_pkg::CH_W-1:0];
				tcr_pkg::REG_FRAME_HEIGHT: n_rows = data;
				tcr_pkg::REG_FRAME_WIDTH: n_cols = data;
				tcr_pkg::REG_TILE_EDGE: tile_len = data;
				default: ;
			endcase
			clear_position();
		endfunction

		function bit sizes_bad();
			if (n_chan < 1 || n_chan > tcr_pkg::MAX_CHANNELS) return 1'b1;
			if (n_rows < 1 || n_rows > tcr_pkg::MAX_EDGE) return 1'b1;
			if (n_cols < 1 || n_cols > tcr_pkg::MAX_EDGE) return 1'b1;
			if (tile_len < 1 || tile_len > tcr_pkg::MAX_EDGE) return 1'b1;
			if (n_rows % tile_len != 0 || n_cols % tile_len != 0) return 1'b1;
			if (longint'(n_chan) * n_rows * n_cols > STORE_DEPTH) return 1'b1;
			return 1'b0;
		endfunction

		function int unsigned next_addr();
			longint row, col;
			row = longint'(tile_r) * tile_len + row_at;
			col = longint'(tile_c) * tile_len + col_at;
			return int'((longint'(chan_at) * n_rows * n_cols + row * n_cols + col)
				% STORE_DEPTH);
		endfunction

		// An emit is only offered when it cannot read an element never loaded.
		function bit emit_ok();
			return sizes_bad() || frame_mem.exists(next_addr());
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_input(bit f, logic [tcr_pkg::VALUE_W-1:0] v);
			tile_result_t r;
			longint lim;
			bit bad, last_col, last_row, last_ch, last_tc, last_tr;
			bad = sizes_bad();
			if (f == FUNC_LOAD) begin
				loads++;
				lim = bad ? STORE_DEPTH : longint'(n_chan) * n_rows * n_cols;
				frame_mem[load_ptr] = v;
				load_ptr = (longint'(load_ptr) + 1 >= lim) ? 0 : load_ptr + 1;
				return;
			end
			emits++;
			r = '0;
			if (bad) begin
				r.cfg_err = 1'b1;
				error_results++;
				awaited.push_back(r);
				return;
			end
			last_col = col_at + 1 >= tile_len;
			last_row = row_at + 1 >= tile_len;
			last_ch = chan_at + 1 >= n_chan;
			last_tc = tile_c + 1 >= n_cols / tile_len;
			last_tr = tile_r + 1 >= n_rows / tile_len;
			r.value = frame_mem[next_addr()];
			r.tile_end = last_col && last_row;
			r.frame_end = r.tile_end && last_ch && last_tc && last_tr;
			tile_marks += r.tile_end;
			frame_marks += r.frame_end;
			awaited.push_back(r);
			if (!last_col) begin
				col_at++;
				return;
			end
			col_at = 0;
			if (!last_row) begin
				row_at++;
				return;
			end
			row_at = 0;
			if (!last_ch) begin
				chan_at++;
				return;
			end
			chan_at = 0;
			if (!last_tc) begin
				tile_c++;
				return;
			end
			tile_c = 0;
			if (!last_tr) begin
				tile_r++;
				return;
			end
			tile_r = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		task check_result(tile_result_t got);
			tile_result_t exp;
			if (awaited.size() == 0) begin
				report($sformatf("result with nothing awaited: value %h tile %b frame %b err %b",
					got.value, got.tile_end, got.frame_end, got.cfg_err));
				return;
			end
			exp = awaited.pop_front();
			if (got.value !== exp.value || got.tile_end !== exp.tile_end
					|| got.frame_end !== exp.frame_end || got.cfg_err !== exp.cfg_err)
				report($sformatf("got value %h tile %b frame %b err %b, expected %h %b %b %b",
					got.value, got.tile_end, got.frame_end, got.cfg_err,
					exp.value, exp.tile_end, exp.frame_end, exp.cfg_err));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [tcr_pkg::VALUE_W-1:0] load_value;
	logic out_valid;
	logic out_ready;
	logic [tcr_pkg::VALUE_W-1:0] element_value;
	logic tile_done;
	logic frame_done;
	logic config_error;
	logic cfg_we;
	logic [tcr_pkg::INDEX_W-1:0] cfg_index;
	logic [tcr_pkg::EDGE_W-1:0] cfg_data;

	tile_order_predictor predictor = new();
	bit send_gaps = 1'b1;
	bit recv_stalls = 1'b1;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int idle_cycles = 0;
	int settings_run = 0;

	tile_crop_reorder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.load_value(load_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.element_value(element_value),
		.tile_done(tile_done),
		.frame_done(frame_done),
		.config_error(config_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall bursts, plus one long hold-off that backs up the input.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				out_ready <= 1'b0;
				hold_taken = 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			predictor.check_result(tile_result_t'({element_value, tile_done, frame_done,
				config_error}));
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer.", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic put(bit f, logic [tcr_pkg::VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (send_gaps && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 18);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		load_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predictor.note_input(f, v);
	endtask

	// Drop valid and let every awaited result and any load still in the pipe drain.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [tcr_pkg::INDEX_W-1:0] idx,
			logic [tcr_pkg::EDGE_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		predictor.write_reg(idx, data);
		repeat (14) @(posedge clk);
	endtask

	task automatic set_sizes(logic [10:0] c, logic [10:0] h, logic [10:0] w, logic [10:0] t);
		settle();
		write_reg(tcr_pkg::REG_CHANNEL_COUNT, c);
		write_reg(tcr_pkg::REG_FRAME_HEIGHT, h);
		write_reg(tcr_pkg::REG_FRAME_WIDTH, w);
		write_reg(tcr_pkg::REG_TILE_EDGE, t);
		settings_run++;
	endtask

	task automatic run_phase(logic [10:0] c, logic [10:0] h, logic [10:0] w, logic [10:0] t,
			int count, int emit_pct, int hold_at);
		bit f;
		set_sizes(c, h, w, t);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			f = ($urandom_range(0, 99) < emit_pct) ? FUNC_EMIT : FUNC_LOAD;
			if (f == FUNC_EMIT && !predictor.emit_ok())
				f = FUNC_LOAD;
			put(f, 16'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		load_value = '0;
		cfg_we = 1'b0;
		cfg_index = tcr_pkg::REG_CHANNEL_COUNT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset sizes: value extremes go in and come back out in the same order.
		put(FUNC_LOAD, 16'h0000);
		put(FUNC_LOAD, 16'hFFFF);
		put(FUNC_LOAD, 16'h8001);
		put(FUNC_LOAD, 16'h7FFE);
		repeat (4) put(FUNC_EMIT, 16'h0000);

		// Zero channels: emit reports the error, the load still lands.
		set_sizes(11'd0, 11'd224, 11'd224, 11'd112);
		put(FUNC_EMIT, 16'hFFFF);
		put(FUNC_LOAD, 16'h1234);
		put(FUNC_EMIT, 16'h0000);

		// Channel write with high bits set, one-element frame: every emit ends tile and frame.
		set_sizes(11'h7F9, 11'd1, 11'd1, 11'd1);
		put(FUNC_LOAD, 16'hBEEF);
		repeat (3) put(FUNC_EMIT, 16'h0000);
		put(FUNC_LOAD, 16'h4321);
		put(FUNC_EMIT, 16'h0000);

		run_phase(11'd2, 11'd4, 11'd4, 11'd2, 150, 60, -1);
		run_phase(11'd4, 11'd2, 11'd6, 11'd2, 120, 55, -1);
		run_phase(11'd1, 11'd3, 11'd3, 11'd3, 60, 50, -1);
		run_phase(11'd3, 11'd4, 11'd2, 11'd1, 100, 55, -1);
		run_phase(11'd4, 11'd8, 11'd4, 11'd4, 150, 70, 40);

		run_phase(11'd2, 11'd5, 11'd4, 11'd2, 14, 50, -1);
		run_phase(11'd1, 11'd4, 11'd6, 11'd4, 12, 50, -1);
		run_phase(11'h7FA, 11'd1024, 11'd1024, 11'd1024, 12, 50, -1);
		run_phase(11'd1, 11'd4, 11'd4, 11'd0, 10, 50, -1);
		run_phase(11'd5, 11'd4, 11'd4, 11'd2, 10, 50, -1);
		run_phase(11'd7, 11'd4, 11'd4, 11'd2, 10, 50, -1);
		run_phase(11'd1, 11'd0, 11'd4, 11'd2, 10, 50, -1);
		run_phase(11'd1, 11'd2047, 11'd4, 11'd1, 10, 50, -1);
		run_phase(11'd1, 11'd4, 11'd0, 11'd2, 10, 50, -1);
		run_phase(11'd1, 11'd4, 11'd1025, 11'd1, 10, 50, -1);
		run_phase(11'd1, 11'd4, 11'd4, 11'd1536, 10, 50, -1);

		// Frames that fill the store exactly, and a last one at the reset sizes.
		run_phase(11'd1, 11'd512, 11'd512, 11'd512, 60, 50, -1);
		run_phase(11'd4, 11'd256, 11'd256, 11'd256, 60, 50, -1);
		run_phase(11'd1, 11'd1024, 11'd256, 11'd256, 60, 50, -1);
		run_phase(11'd1, 11'd256, 11'd1024, 11'd256, 40, 50, -1);
		run_phase(11'd3, 11'd224, 11'd224, 11'd112, 40, 50, -1);

		settle();
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		run_phase(11'd2, 11'd4, 11'd4, 11'd2, 250, 55, -1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d loads and %0d emits under %0d size settings.",
			predictor.loads, predictor.emits, settings_run);
		$display("Saw %0d tile ends, %0d frame ends and %0d size-error results; %0d mismatches.",
			predictor.tile_marks, predictor.frame_marks, predictor.error_results,
			predictor.fail_count);
		if (predictor.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
